/* design/suv_pkg.sv */
// Package for the strict UTF-8 text validator: widths, codes, state and config types.
`default_nettype none
package suv_pkg;

	localparam int COUNT_W = 17;
	localparam int CP_W    = 21;

	localparam logic [COUNT_W-1:0] COUNT_MAX    = 17'h1FFFF;
	localparam logic [COUNT_W-1:0] CAP_RESET    = 17'd256;

	// register indexes on the write port
	localparam logic REG_BYTE_CAPACITY = 1'b0;
	localparam logic REG_ALLOW_EMPTY   = 1'b1;

	// byte classes and code point limits
	localparam logic [7:0] LEAD2_LO  = 8'hC2;
	localparam logic [7:0] LEAD2_HI  = 8'hDF;
	localparam logic [7:0] LEAD3_LO  = 8'hE0;
	localparam logic [7:0] LEAD3_HI  = 8'hEF;
	localparam logic [7:0] LEAD4_LO  = 8'hF0;
	localparam logic [7:0] LEAD4_HI  = 8'hF4;
	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_TAG  = 8'h80;
	localparam logic [7:0] CHR_TAB   = 8'h09;
	localparam logic [7:0] CHR_LF    = 8'h0A;
	localparam logic [7:0] CHR_CR    = 8'h0D;
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_DEL   = 8'h7F;

	localparam logic [CP_W-1:0] CP_MIN3     = 21'h000800;
	localparam logic [CP_W-1:0] CP_MIN4     = 21'h010000;
	localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h00D800;
	localparam logic [CP_W-1:0] CP_SURR_HI  = 21'h00DFFF;
	localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;

	localparam logic [1:0] SEQ_TWO   = 2'd1;
	localparam logic [1:0] SEQ_THREE = 2'd2;
	localparam logic [1:0] SEQ_FOUR  = 2'd3;

	typedef struct packed {
		logic [COUNT_W-1:0] byte_count;
		logic               error_seen;
		logic [1:0]         bytes_pending;
		logic [1:0]         sequence_length;
		logic [CP_W-1:0]    code_point;
	} text_state_t;

	typedef struct packed {
		logic [COUNT_W-1:0] byte_capacity;
		logic               allow_empty;
	} cfg_t;

endpackage
`default_nettype wire

/* design/suv_chan_if.sv */
// Stream channel interfaces for the validator: byte input and verdict output.
`default_nettype none
interface suv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface suv_out_if;
	logic valid;
	logic ready;
	logic text_valid;

	modport source (output valid, output text_valid, input ready);
	modport sink   (input valid, input text_valid, output ready);
endinterface
`default_nettype wire

/* design/suv_cfg_regs.sv */
// Configuration registers of the validator: byte capacity and empty-text enable.
`default_nettype none
module suv_cfg_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire logic                         wr_index,
	input  wire logic [suv_pkg::COUNT_W-1:0]  wr_data,
	output suv_pkg::cfg_t                     cfg
);

	suv_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.byte_capacity <= suv_pkg::CAP_RESET;
			cfg_q.allow_empty   <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				suv_pkg::REG_BYTE_CAPACITY: cfg_q.byte_capacity <= wr_data;
				suv_pkg::REG_ALLOW_EMPTY:   cfg_q.allow_empty   <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* design/suv_byte_decode.sv */
// Next-state logic for one data byte: length count and UTF-8 sequence checks.
`default_nettype none
module suv_byte_decode (
	input  wire suv_pkg::text_state_t  cur,
	input  wire logic [7:0]            text_byte,
	output suv_pkg::text_state_t       nxt
);

	logic [suv_pkg::CP_W-1:0] cp_shift;
	logic [1:0]               pend_dec;

	always_comb begin
		cp_shift = {cur.code_point[suv_pkg::CP_W-7:0], text_byte[5:0]};
		pend_dec = cur.bytes_pending - 2'd1;
		nxt = cur;

		if (cur.byte_count < suv_pkg::COUNT_MAX) begin
			nxt.byte_count = cur.byte_count + suv_pkg::COUNT_W'(1);
		end

		if (!cur.error_seen) begin
			if (cur.bytes_pending != 2'd0) begin
				// inside a multibyte sequence
				if ((text_byte & suv_pkg::CONT_MASK) != suv_pkg::CONT_TAG) begin
					nxt.error_seen    = 1'b1;
					nxt.bytes_pending = 2'd0;
				end else begin
					nxt.code_point    = cp_shift;
					nxt.bytes_pending = pend_dec;
					if (pend_dec == 2'd0) begin
						if ((cur.sequence_length == suv_pkg::SEQ_THREE &&
						     cp_shift < suv_pkg::CP_MIN3) ||
						    (cur.sequence_length == suv_pkg::SEQ_FOUR &&
						     cp_shift < suv_pkg::CP_MIN4) ||
						    (cp_shift >= suv_pkg::CP_SURR_LO &&
						     cp_shift <= suv_pkg::CP_SURR_HI) ||
						    cp_shift > suv_pkg::CP_MAX) begin
							nxt.error_seen = 1'b1;
						end
					end
				end
			end else if (!text_byte[7]) begin
				// ASCII: only tab, LF and CR below space, no DEL
				if ((text_byte < suv_pkg::CHR_SPACE && text_byte != suv_pkg::CHR_TAB &&
				     text_byte != suv_pkg::CHR_LF && text_byte != suv_pkg::CHR_CR) ||
				    text_byte == suv_pkg::CHR_DEL) begin
					nxt.error_seen = 1'b1;
				end
			end else if (text_byte >= suv_pkg::LEAD2_LO && text_byte <= suv_pkg::LEAD2_HI) begin
				nxt.code_point      = {16'd0, text_byte[4:0]};
				nxt.sequence_length = suv_pkg::SEQ_TWO;
				nxt.bytes_pending   = suv_pkg::SEQ_TWO;
			end else if (text_byte >= suv_pkg::LEAD3_LO && text_byte <= suv_pkg::LEAD3_HI) begin
				nxt.code_point      = {17'd0, text_byte[3:0]};
				nxt.sequence_length = suv_pkg::SEQ_THREE;
				nxt.bytes_pending   = suv_pkg::SEQ_THREE;
			end else if (text_byte >= suv_pkg::LEAD4_LO && text_byte <= suv_pkg::LEAD4_HI) begin
				nxt.code_point      = {18'd0, text_byte[2:0]};
				nxt.sequence_length = suv_pkg::SEQ_FOUR;
				nxt.bytes_pending   = suv_pkg::SEQ_FOUR;
			end else begin
				nxt.error_seen = 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* design/strict_utf8_text_validator.sv */
// Top level of the strict UTF-8 text validator: input stage, text state, verdict register.
//
//  channel  dir  payload                         transfer
//  in       in   text_byte[7:0], end_of_text     valid & ready
//  out      out  text_valid                      valid & ready
//  wr_*     in   wr_index, wr_data[16:0]         wr_en
//
// One byte per cycle sustained while no terminator is held by a stall on out; no bubbles between texts.
// A terminator passes the input stage, then its verdict is loaded into the verdict
// register and shown on out, where it waits for an out transfer.
// arst_n clears the text state, both valid flags and loads the register defaults.
// A stall on out holds one verdict in the output register; data bytes keep
// flowing behind it, a second terminator waits in the input stage.
`default_nettype none
module strict_utf8_text_validator (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	suv_in_if.sink                           in,
	suv_out_if.source                        out,
	input  wire logic                        wr_en,
	input  wire logic                        wr_index,
	input  wire logic [suv_pkg::COUNT_W-1:0] wr_data
);

	suv_pkg::cfg_t        cfg;
	suv_pkg::text_state_t state_q;
	suv_pkg::text_state_t state_nxt;

	// input stage
	logic       valid_s1;
	logic [7:0] text_byte_s1;
	logic       eot_s1;

	// verdict register
	logic out_valid_q;
	logic text_valid_q;

	logic s1_fire;
	logic verdict;

	suv_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	suv_byte_decode u_dec (
		.cur       (state_q),
		.text_byte (text_byte_s1),
		.nxt       (state_nxt)
	);

	// data bytes always retire; a terminator needs a free verdict slot
	assign s1_fire  = valid_s1 && (!eot_s1 || !out_valid_q || out.ready);
	assign in.ready = !valid_s1 || s1_fire;

	assign verdict = !state_q.error_seen && (state_q.bytes_pending == 2'd0) &&
	                 (state_q.byte_count < cfg.byte_capacity) &&
	                 (cfg.allow_empty || state_q.byte_count != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (in.ready) begin
				valid_s1 <= in.valid;
			end
			if (s1_fire) begin
				// terminator clears the text state, data byte advances it
				state_q <= eot_s1 ? '0 : state_nxt;
			end
			if (s1_fire && eot_s1) begin
				out_valid_q <= 1'b1;
			end else if (out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in.ready && in.valid) begin
			text_byte_s1 <= in.text_byte;
			eot_s1       <= in.end_of_text;
		end
		if (s1_fire && eot_s1) begin
			text_valid_q <= verdict;
		end
	end

	assign out.valid      = out_valid_q;
	assign out.text_valid = text_valid_q;

`ifndef SYNTH
	a_clear_after_eot: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && eot_s1) |=> (state_q.byte_count == '0 && !state_q.error_seen &&
		                         state_q.bytes_pending == 2'd0))
		else $error("text state not cleared after terminator");

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.byte_count == suv_pkg::COUNT_MAX && !(s1_fire && eot_s1))
		|=> state_q.byte_count == suv_pkg::COUNT_MAX)
		else $error("byte count left saturation");

	a_verdict_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_fire && eot_s1))
		else $error("verdict raised without terminator");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.bytes_pending <= state_q.sequence_length)
		else $error("pending bytes exceed sequence length");
`endif

endmodule
`default_nettype wire
